// File: design/zbs_pkg.sv
// Shared types and constants for the z-buffered span shader.
package zbs_pkg;

	// Operation carried by an input word.
	typedef enum logic [0:0] {
		OP_CLEAR = 1'b0,
		OP_FILL  = 1'b1
	} opcode_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_SURFACE_COLOR  = 3'd0;
	localparam logic [2:0] REG_PLANE_DZ_DX    = 3'd1;
	localparam logic [2:0] REG_PLANE_DZ_DY    = 3'd2;
	localparam logic [2:0] REG_PLANE_Z_OFFSET = 3'd3;
	localparam logic [2:0] REG_AMBIENT_LIGHT  = 3'd4;
	localparam logic [2:0] REG_POINT_LIGHT    = 3'd5;
	localparam logic [2:0] REG_VIEWER_DIST    = 3'd6;
	localparam logic [2:0] REG_WINDOW_LEFT    = 3'd7;

	// Farthest depth, the value of an entry that was cleared.
	localparam logic signed [31:0] FAR_DEPTH = 32'sh7FFFFFFF;

	// Attenuation divider widths: light times distance over distance squared.
	localparam int NUM_W = 48;
	localparam int DEN_W = 46;
	localparam int QUO_W = 17;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [11:0] line_y;
		logic signed [15:0] span_left;
		logic signed [15:0] span_right;
	} in_word_t;

	typedef struct packed {
		logic signed [12:0] pixel_x;
		logic signed [11:0] pixel_y;
		logic               pixel_written;
		logic [7:0]         red_out;
		logic [7:0]         green_out;
		logic [7:0]         blue_out;
		logic signed [31:0] depth_out;
		logic               last_of_span;
	} out_word_t;

endpackage

// File: design/zbs_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module zbs_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [zbs_pkg::NUM_W-1:0]   num,
	input  logic [zbs_pkg::DEN_W-1:0]   den,
	output logic                        done,
	output logic [zbs_pkg::QUO_W-1:0]   quot
);

	localparam int NW = zbs_pkg::NUM_W;
	localparam int DW = zbs_pkg::DEN_W;
	localparam int QW = zbs_pkg::QUO_W;

	logic [DW-1:0]       rem_q;
	logic [DW-1:0]       den_q;
	logic [QW-1:0]       bits_q;
	logic [QW-1:0]       quot_q;
	logic [4:0]          cnt_q;
	logic                run_q;
	logic                done_q;
	logic [DW:0]         trial;
	logic [DW:0]         diff;

	// One trial subtraction with the next numerator bit shifted in.
	assign trial = {rem_q, bits_q[QW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'(QW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath; the upper numerator bits are already below the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DW'(num[NW-1:QW]);
			bits_q <= num[QW-1:0];
			den_q  <= den;
			quot_q <= '0;
		end else if (run_q) begin
			bits_q <= {bits_q[QW-2:0], 1'b0};
			if (!diff[DW]) begin
				rem_q  <= diff[DW-1:0];
				quot_q <= {quot_q[QW-2:0], 1'b1};
			end else begin
				rem_q  <= trial[DW-1:0];
				quot_q <= {quot_q[QW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: design/zbs_depth_mem.sv
// One-line depth store with per-entry valid bits and a registered read.
module zbs_depth_mem #(
	parameter int LINE_WIDTH = 64,
	parameter int AW = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic [AW-1:0]       raddr,
	output logic signed [31:0]  rdata,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic signed [31:0]  wdata
);

	logic signed [31:0]      mem [LINE_WIDTH];
	logic [LINE_WIDTH-1:0]   vld_q;
	logic signed [31:0]      rdata_q;
	logic                    rvld_q;

	// Valid bits make a cleared entry read as farthest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[raddr];
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rvld_q ? rdata_q : zbs_pkg::FAR_DEPTH;

endmodule

// File: design/zbuffer_span_shader_core.sv
// Top level: span sequencer, plane stepping, depth test and shading.
// Sequence: a fill word passes setup states S_SETUP_A, S_SETUP_B and S_SETUP_C, then each
// pixel passes S_READ, S_TEST, S_MUL, S_SHADE and S_EMIT, with S_DIV after S_MUL when the
// pixel passes the depth test and 0 < D - z <= (D squared >> 16). One word at a time:
// a clear word leaves the block idle and an empty span returns to idle after S_SETUP_A. The
// receiver cannot stall: each result word is shown for one cycle under result_strobe.
// Reset clears the sequencer, loads the register defaults and marks every depth entry
// farthest at once.
module zbuffer_span_shader_core #(
	parameter int LINE_WIDTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  zbs_pkg::in_word_t   item,
	output logic                result_strobe,
	output zbs_pkg::out_word_t  result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int AW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
	localparam int DW = zbs_pkg::DEN_W;
	localparam int QW = zbs_pkg::QUO_W;

	typedef enum logic [3:0] {
		S_IDLE, S_SETUP_A, S_SETUP_B, S_SETUP_C, S_READ, S_TEST,
		S_MUL, S_DIV, S_SHADE, S_EMIT
	} state_t;

	// Configuration registers.
	logic [23:0]        color_q;
	logic signed [31:0] dzdx_q;
	logic signed [31:0] dzdy_q;
	logic signed [31:0] zoff_q;
	logic [15:0]        amb_q;
	logic [15:0]        plight_q;
	logic [30:0]        dist_q;
	logic signed [11:0] wleft_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q  <= 24'hFFFFFF;
			dzdx_q   <= '0;
			dzdy_q   <= '0;
			zoff_q   <= '0;
			amb_q    <= 16'd16384;
			plight_q <= '0;
			dist_q   <= 31'd16777216;
			wleft_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				zbs_pkg::REG_SURFACE_COLOR:  color_q  <= cfg_data[23:0];
				zbs_pkg::REG_PLANE_DZ_DX:    dzdx_q   <= cfg_data;
				zbs_pkg::REG_PLANE_DZ_DY:    dzdy_q   <= cfg_data;
				zbs_pkg::REG_PLANE_Z_OFFSET: zoff_q   <= cfg_data;
				zbs_pkg::REG_AMBIENT_LIGHT:  amb_q    <= cfg_data[15:0];
				zbs_pkg::REG_POINT_LIGHT:    plight_q <= cfg_data[15:0];
				zbs_pkg::REG_VIEWER_DIST:    dist_q   <= cfg_data[30:0];
				zbs_pkg::REG_WINDOW_LEFT:    wleft_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// Round a Q11.4 edge to integer x, half away from zero.
	function automatic logic signed [12:0] round_edge(input logic signed [15:0] e);
		logic [16:0] mag;
		logic [12:0] r;
		mag = e[15] ? 17'(-{e[15], e}) : {1'b0, e};
		r   = 13'((mag + 17'd8) >> 4);
		return e[15] ? -$signed(r) : $signed(r);
	endfunction

	state_t             state_q;
	logic signed [11:0] y_q;
	logic signed [12:0] x_q;
	logic signed [12:0] x1_q;
	logic signed [47:0] z_q;
	logic signed [47:0] prod_q;
	logic [DW-1:0]      dsq_q;
	logic signed [31:0] zs_q;
	logic               pass_q;
	logic [QW-1:0]      term_q;
	logic [24:0]        rp_q;
	logic [24:0]        gp_q;
	logic [24:0]        bp_q;
	logic               strobe_q;
	zbs_pkg::out_word_t res_q;

	logic               accept;
	logic signed [12:0] wl13;
	logic signed [12:0] wr13;
	logic signed [12:0] xl;
	logic signed [12:0] xr;
	logic signed [12:0] idx;
	logic signed [31:0] stored;
	logic signed [31:0] zsat;
	logic signed [32:0] dq;
	logic [47:0]        num;
	logic               div_go;
	logic               div_done;
	logic [QW-1:0]      quot;
	logic [16:0]        light;
	logic               mem_clr;
	logic               mem_we;

	assign accept = start && !busy;
	assign wl13   = 13'(wleft_q);
	assign wr13   = wl13 + 13'(LINE_WIDTH);
	assign xl     = round_edge(item.span_left);
	assign xr     = round_edge(item.span_right);
	assign idx    = x_q - wl13;

	// Depth saturated to 32 bits.
	always_comb begin
		priority if (z_q > 48'sh7FFFFFFF) zsat = 32'sh7FFFFFFF;
		else if (z_q < -48'sh80000000)    zsat = -32'sh80000000;
		else                              zsat = z_q[31:0];
	end

	// Distance term: divide only when 0 < D - z <= (D squared >> 16).
	assign dq     = $signed({2'b00, dist_q}) - 33'(zs_q);
	assign num    = 48'(plight_q) * 48'(dq[31:0]);
	assign div_go = (state_q == S_MUL) && pass_q && !dq[32] && (dq != '0)
			&& ({{(DW-32){1'b0}}, dq[31:0]} <= dsq_q);
	assign light  = 17'(amb_q) + term_q;

	assign mem_clr = accept && (item.opcode == zbs_pkg::OP_CLEAR);
	assign mem_we  = (state_q == S_MUL) && pass_q;

	zbs_depth_mem #(
		.LINE_WIDTH(LINE_WIDTH),
		.AW(AW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (mem_clr),
		.raddr (idx[AW-1:0]),
		.rdata (stored),
		.we    (mem_we),
		.waddr (idx[AW-1:0]),
		.wdata (zs_q)
	);

	zbs_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go),
		.num   (num),
		.den   (dsq_q),
		.done  (div_done),
		.quot  (quot)
	);

	// Saturate one shaded channel to 8 bits.
	function automatic logic [7:0] sat8(input logic [24:0] p);
		return (p[24:14] > 11'd255) ? 8'hFF : p[21:14];
	endfunction

	// Sequencer and its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && item.opcode == zbs_pkg::OP_FILL) begin
						y_q     <= item.line_y;
						x_q     <= (xl < wl13) ? wl13 : xl;
						x1_q    <= (xr > wr13) ? wr13 : xr;
						state_q <= S_SETUP_A;
					end
				end
				S_SETUP_A: begin
					prod_q  <= 48'(dzdx_q) * 48'(x_q);
					state_q <= (x_q >= x1_q) ? S_IDLE : S_SETUP_B;
				end
				S_SETUP_B: begin
					z_q     <= prod_q + 48'(zoff_q);
					prod_q  <= 48'(dzdy_q) * 48'(y_q);
					state_q <= S_SETUP_C;
				end
				S_SETUP_C: begin
					z_q     <= z_q + prod_q;
					dsq_q   <= DW'((62'(dist_q) * 62'(dist_q)) >> 16);
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_TEST;
				end
				S_TEST: begin
					zs_q    <= zsat;
					pass_q  <= stored > zsat;
					state_q <= S_MUL;
				end
				S_MUL: begin
					term_q  <= QW'(plight_q);
					state_q <= div_go ? S_DIV : S_SHADE;
				end
				S_DIV: begin
					if (div_done) begin
						term_q  <= quot;
						state_q <= S_SHADE;
					end
				end
				S_SHADE: begin
					rp_q    <= 25'(color_q[23:16]) * 25'(light);
					gp_q    <= 25'(color_q[15:8]) * 25'(light);
					bp_q    <= 25'(color_q[7:0]) * 25'(light);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					strobe_q            <= 1'b1;
					res_q.pixel_x       <= x_q;
					res_q.pixel_y       <= y_q;
					res_q.pixel_written <= pass_q;
					res_q.red_out       <= pass_q ? sat8(rp_q) : 8'd0;
					res_q.green_out     <= pass_q ? sat8(gp_q) : 8'd0;
					res_q.blue_out      <= pass_q ? sat8(bp_q) : 8'd0;
					res_q.depth_out     <= zs_q;
					res_q.last_of_span  <= (x_q == x1_q - 13'sd1);
					x_q                 <= x_q + 13'sd1;
					z_q                 <= z_q + 48'(dzdx_q);
					state_q             <= (x_q == x1_q - 13'sd1) ? S_IDLE : S_READ;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign result_strobe = strobe_q;
	assign result        = res_q;

	// A clear word finishes in the cycle it is taken.
	a_clear_quick: assert property (@(posedge clk) disable iff (!arst_n)
		mem_clr |=> !busy) else $error("clear word left the block busy");

	// A fill word always starts the sequencer.
	a_fill_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.opcode == zbs_pkg::OP_FILL) |=> busy)
		else $error("fill word not started");

	// Result strobes never come back to back.
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe) else $error("back-to-back result strobes");

	// The divider only finishes while the sequencer waits on it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV)) else $error("divider done outside divide state");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the z-buffered span shader core.
`timescale 1ns / 1ps

module testbench;

	localparam int LINE_W      = 64;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE      = 40;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	zbs_pkg::in_word_t  item;
	logic               result_strobe;
	zbs_pkg::out_word_t result;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	zbuffer_span_shader_core #(.LINE_WIDTH(LINE_W)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_strobe(result_strobe), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the block state and registers.
	logic signed [31:0] depth_mem [LINE_W];
	logic [23:0]        surf_color;
	logic signed [31:0] dz_dx, dz_dy, z_off;
	logic [15:0]        ambient, point_light;
	logic [30:0]        eye_dist;
	logic signed [11:0] win_left;

	zbs_pkg::out_word_t pixel_queue[$];
	int                 mismatches;
	int                 quiet_cycles;
	bit                 allow_gaps;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Stall watchdog: no word moving in either direction for too long.
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe)
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Compare each result word with the oldest predicted pixel.
	always @(posedge clk) begin
		zbs_pkg::out_word_t want;
		if (arst_n && result_strobe) begin
			if (pixel_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", result);
			end else begin
				want = pixel_queue.pop_front();
				if (want !== result) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: x exp %0d got %0d, y %0d/%0d, ",
							"wr %0b/%0b, rgb %h%h%h/%h%h%h, z %h/%h, last %0b/%0b"},
							want.pixel_x, result.pixel_x, want.pixel_y, result.pixel_y,
							want.pixel_written, result.pixel_written,
							want.red_out, want.green_out, want.blue_out,
							result.red_out, result.green_out, result.blue_out,
							want.depth_out, result.depth_out,
							want.last_of_span, result.last_of_span);
				end
			end
		end
	end

	function automatic logic [7:0] shade_channel(longint c, longint light);
		longint v;
		v = (c * light) >>> 14;
		return (v > 255) ? 8'hFF : v[7:0];
	endfunction

	function automatic longint round_edge_x(logic signed [15:0] e);
		longint v;
		v = longint'(e);
		return (v >= 0) ? (v + 8) / 16 : -((-v + 8) / 16);
	endfunction

	// Work out the pixels one accepted word produces and update the depth copy.
	task automatic predict_span(zbs_pkg::in_word_t w);
		longint y, wl, x0, x1, z, zs, dsq, dq, term, light;
		longint unsigned dd;
		zbs_pkg::out_word_t px;
		if (w.opcode == zbs_pkg::OP_CLEAR) begin
			foreach (depth_mem[i]) depth_mem[i] = zbs_pkg::FAR_DEPTH;
			return;
		end
		y  = longint'(w.line_y);
		wl = longint'(win_left);
		x0 = round_edge_x(w.span_left);
		x1 = round_edge_x(w.span_right);
		if (x0 < wl) x0 = wl;
		if (x1 > wl + LINE_W) x1 = wl + LINE_W;
		z = longint'(dz_dx) * x0 + longint'(dz_dy) * y + longint'(z_off);
		dd = longint'(eye_dist);
		dsq = longint'((dd * dd) >> 16);
		for (longint x = x0; x < x1; x++) begin
			zs = (z > 64'sd2147483647) ? 64'sd2147483647 :
				(z < -64'sd2147483648) ? -64'sd2147483648 : z;
			px = '0;
			px.pixel_x = x[12:0];
			px.pixel_y = w.line_y;
			px.depth_out = zs[31:0];
			px.last_of_span = (x == x1 - 1);
			if (longint'(depth_mem[x - wl]) > zs) begin
				depth_mem[x - wl] = zs[31:0];
				px.pixel_written = 1'b1;
				dq = longint'(dd) - zs;
				if (dq <= 0 || dq > dsq)
					term = longint'(point_light);
				else
					term = longint'(point_light) * dq / dsq;
				light = longint'(ambient) + term;
				px.red_out   = shade_channel(longint'(surf_color[23:16]), light);
				px.green_out = shade_channel(longint'(surf_color[15:8]), light);
				px.blue_out  = shade_channel(longint'(surf_color[7:0]), light);
			end
			pixel_queue.push_back(px);
			z += longint'(dz_dx);
		end
	endtask

	// Send one word; returns just after a falling edge, with start still high unless a random gap was taken.
	task automatic send_word(zbs_pkg::opcode_t op, logic signed [11:0] y,
			logic signed [15:0] l, logic signed [15:0] r);
		zbs_pkg::in_word_t w;
		w.opcode = op;
		w.line_y = y;
		w.span_left = l;
		w.span_right = r;
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		predict_span(w);
		@(negedge clk);
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic fill(logic signed [11:0] y, logic signed [15:0] l, logic signed [15:0] r);
		send_word(zbs_pkg::OP_FILL, y, l, r);
	endtask

	// Wait until every predicted pixel has come out and the block has settled.
	task automatic drain();
		start <= 1'b0;
		while (pixel_queue.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		start <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			zbs_pkg::REG_SURFACE_COLOR:  surf_color = val[23:0];
			zbs_pkg::REG_PLANE_DZ_DX:    dz_dx = val;
			zbs_pkg::REG_PLANE_DZ_DY:    dz_dy = val;
			zbs_pkg::REG_PLANE_Z_OFFSET: z_off = val;
			zbs_pkg::REG_AMBIENT_LIGHT:  ambient = val[15:0];
			zbs_pkg::REG_POINT_LIGHT:    point_light = val[15:0];
			zbs_pkg::REG_VIEWER_DIST:    eye_dist = val[30:0];
			zbs_pkg::REG_WINDOW_LEFT:    win_left = val[11:0];
			default: ;
		endcase
	endtask

	task automatic load_plane(logic [31:0] dx, logic [31:0] dy, logic [31:0] off);
		write_reg(zbs_pkg::REG_PLANE_DZ_DX, dx);
		write_reg(zbs_pkg::REG_PLANE_DZ_DY, dy);
		write_reg(zbs_pkg::REG_PLANE_Z_OFFSET, off);
	endtask

	// Defaults after reset, rounding of edges, clipping and empty spans.
	task automatic test_edges();
		fill(12'sd0, 16'sd0, 16'sd64);
		fill(12'sd0, 16'sd0, 16'sd64);
		send_word(zbs_pkg::OP_CLEAR, 12'sd0, 16'sd0, 16'sd0);
		fill(-12'sd2048, -16'sd32768, 16'sd32767);
		fill(12'sd2047, 16'sd8, 16'sd24);
		fill(12'sd5, -16'sd8, -16'sd24);
		fill(12'sd5, 16'sd7, 16'sd40);
		fill(12'sd5, 16'sd100, 16'sd40);
		drain();
	endtask

	// Depth test, shading saturation and the attenuation branches.
	task automatic test_shading();
		write_reg(zbs_pkg::REG_SURFACE_COLOR, 32'h00FF8001);
		write_reg(zbs_pkg::REG_AMBIENT_LIGHT, 32'h0000FFFF);
		write_reg(zbs_pkg::REG_POINT_LIGHT, 32'h0000FFFF);
		write_reg(zbs_pkg::REG_VIEWER_DIST, 32'h0);
		write_reg(zbs_pkg::REG_WINDOW_LEFT, 32'h00000800);
		load_plane(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_word(zbs_pkg::OP_CLEAR, 12'sd0, 16'sd0, 16'sd0);
		fill(12'sd1, -16'sd32768, 16'sd32767);
		fill(-12'sd2048, -16'sd32768, 16'sd32767);
		drain();
		write_reg(zbs_pkg::REG_WINDOW_LEFT, 32'h000007FF);
		write_reg(zbs_pkg::REG_VIEWER_DIST, 32'h7FFFFFFF);
		write_reg(zbs_pkg::REG_AMBIENT_LIGHT, 32'h0);
		write_reg(zbs_pkg::REG_SURFACE_COLOR, 32'h0);
		load_plane(32'h00010000, 32'h0, 32'h00100000);
		send_word(zbs_pkg::OP_CLEAR, 12'sd0, 16'sd0, 16'sd0);
		fill(12'sd3, 16'sd32767, 16'sd32767);
		fill(12'sd3, -16'sd32768, 16'sd32767);
		drain();
		// Near viewer so that some pixels sit behind the eye distance.
		write_reg(zbs_pkg::REG_WINDOW_LEFT, 32'h0);
		write_reg(zbs_pkg::REG_SURFACE_COLOR, 32'h00FFFFFF);
		write_reg(zbs_pkg::REG_AMBIENT_LIGHT, 32'h00001000);
		write_reg(zbs_pkg::REG_POINT_LIGHT, 32'h00008000);
		write_reg(zbs_pkg::REG_VIEWER_DIST, 32'h00010000);
		load_plane(32'h00004000, 32'h0, 32'h0);
		send_word(zbs_pkg::OP_CLEAR, 12'sd0, 16'sd0, 16'sd0);
		fill(12'sd0, 16'sd0, 16'sd1024);
		drain();
		load_plane(32'hFFFFC000, 32'h0, 32'h00020000);
		fill(12'sd0, 16'sd0, 16'sd1024);
		drain();
	endtask

	function automatic logic [31:0] rand_plane_term();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'(int'($urandom_range(0, 8192)) - 4096);
			default: return 32'(int'($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	task automatic random_config();
		write_reg(zbs_pkg::REG_SURFACE_COLOR, $urandom);
		load_plane(rand_plane_term(), rand_plane_term(),
			($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 32'h00400000)));
		write_reg(zbs_pkg::REG_AMBIENT_LIGHT,
			$urandom_range(0, 1) ? $urandom : $urandom_range(0, 16384));
		write_reg(zbs_pkg::REG_POINT_LIGHT, $urandom);
		write_reg(zbs_pkg::REG_VIEWER_DIST,
			$urandom_range(0, 1) ? $urandom : $urandom_range(65536, 32'h00400000));
		write_reg(zbs_pkg::REG_WINDOW_LEFT,
			$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200) - 100);
	endtask

	// Random spans: mostly near the window and short, sometimes anything.
	task automatic test_random(int words);
		longint lx, w;
		logic signed [15:0] l, r;
		for (int i = 0; i < words; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_word(zbs_pkg::OP_CLEAR, 12'($urandom), 16'($urandom), 16'($urandom));
			else if ($urandom_range(0, 7) == 0)
				fill(12'($urandom), 16'($urandom), 16'($urandom));
			else begin
				lx = longint'(win_left) + $urandom_range(0, 80) - 8;
				w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 12);
				l = 16'(lx * 16 + $urandom_range(0, 15) - 8);
				r = 16'((lx + w) * 16 + $urandom_range(0, 15) - 8);
				fill(12'($urandom), l, r);
			end
		end
	endtask

	initial begin
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = zbs_pkg::REG_SURFACE_COLOR;
		cfg_data = '0;
		arst_n = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		allow_gaps = 1'b1;
		foreach (depth_mem[i]) depth_mem[i] = zbs_pkg::FAR_DEPTH;
		surf_color = 24'hFFFFFF;
		dz_dx = '0;
		dz_dy = '0;
		z_off = '0;
		ambient = 16'd16384;
		point_light = '0;
		eye_dist = 31'd16777216;
		win_left = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_edges();
		test_shading();
		for (int phase = 0; phase < 4; phase++) begin
			random_config();
			allow_gaps = (phase < 3);
			test_random(26);
			// Let the pipeline empty completely before the next setting.
			drain();
		end

		if (mismatches == 0 && pixel_queue.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
design/zbs_pkg.sv
design/zbs_divider.sv
design/zbs_depth_mem.sv
design/zbuffer_span_shader_core.sv
sim/testbench.sv
